[sv/dcr_pkg.sv]
// ----------------------------------------------------------------------------
// Disk graph chain reaction: shared types
// Word layouts of the item and result channels, operation codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dcr_pkg;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_ROCKET = 2'd1;
	localparam logic [1:0] OP_REACH  = 2'd2;
	localparam logic [1:0] OP_BEST   = 2'd3;

	// Width of a mine index or count as carried in commands and status.
	localparam int J_W = 7;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [5:0]         mine_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [14:0]        radius;
	} item_t;

	typedef struct packed {
		logic [5:0] result_index;
		logic       has_index;
		logic [6:0] result_count;
		logic       status;
		logic       last_item;
	} result_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_ERR,
		KIND_REACH,
		KIND_BEST,
		KIND_PEND
	} kind_t;

	typedef struct packed {
		logic             wr_mine;
		logic             cov_go;
		logic             cov_mode;
		logic             adj_row;
		logic             adj_col;
		logic             seed_clear;
		logic             seed_one;
		logic             seed_set;
		logic             walk_pick;
		logic             pop_rd;
		logic             pop_load;
		logic             best_upd;
		logic             best_first;
		logic             out_load;
		kind_t            kind;
		logic [J_W-1:0]   j;
	} cmd_t;

	typedef struct packed {
		logic [1:0]     op;
		logic [J_W-1:0] idx;
		logic [J_W-1:0] n;
		logic           cov_done;
		logic           top_nz;
		logic           sp_nz;
		logic           out_empty;
		logic           pend_valid;
	} sts_t;

endpackage

[sv/dcr_if.sv]
// ----------------------------------------------------------------------------
// Disk graph chain reaction: channel interfaces
// Valid/ready channels for items, results and the mine count register.
// ----------------------------------------------------------------------------
interface dcr_item_if;
	logic           valid;
	logic           ready;
	dcr_pkg::item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dcr_res_if;
	logic             valid;
	logic             ready;
	dcr_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dcr_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/dcr_ram.sv]
// ----------------------------------------------------------------------------
// Disk graph chain reaction: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/dcr_ctrl.sv]
// ----------------------------------------------------------------------------
// Disk graph chain reaction: controller
// Sequences mine writes, rocket seeding, depth-first walks and best search.
// ----------------------------------------------------------------------------
module dcr_ctrl #(
	parameter int MAX_MINES = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  dcr_pkg::sts_t sts,
	output dcr_pkg::cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_WA, S_WAW, S_WBW, S_RSEED, S_RWAIT,
		S_WALK, S_SETTLE, S_POPW, S_SEED3, S_FINAL
	} state_t;

	state_t                 state_q;
	logic                   ready_q;
	dcr_pkg::cmd_t          cmd_q;
	dcr_pkg::kind_t         kind_q;
	logic [dcr_pkg::J_W-1:0] j_q;

	localparam logic [dcr_pkg::J_W-1:0] MAX_J = dcr_pkg::J_W'(MAX_MINES);

	assign item_ready = ready_q;
	assign cmd        = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
			cmd_q   <= '0;
			kind_q  <= dcr_pkg::KIND_NONE;
			j_q     <= '0;
		end else begin
			cmd_q   <= '0;
			cmd_q.j <= j_q;
			unique case (state_q)
				S_IDLE: begin
					if (item_valid && ready_q) begin
						ready_q <= 1'b0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					j_q <= '0;
					unique case (sts.op)
						dcr_pkg::OP_WRITE: begin
							if (sts.idx >= sts.n) begin
								kind_q  <= dcr_pkg::KIND_ERR;
								state_q <= S_FINAL;
							end else begin
								cmd_q.wr_mine <= 1'b1;
								state_q       <= S_WA;
							end
						end
						dcr_pkg::OP_ROCKET: begin
							cmd_q.seed_clear <= 1'b1;
							state_q          <= S_RSEED;
						end
						dcr_pkg::OP_REACH: begin
							if (sts.idx >= sts.n) begin
								kind_q  <= dcr_pkg::KIND_ERR;
								state_q <= S_FINAL;
							end else begin
								cmd_q.seed_one <= 1'b1;
								cmd_q.j        <= sts.idx;
								state_q        <= S_SETTLE;
							end
						end
						default: begin
							if (sts.n == '0) begin
								kind_q  <= dcr_pkg::KIND_ERR;
								state_q <= S_FINAL;
							end else begin
								cmd_q.seed_one <= 1'b1;
								cmd_q.j        <= '0;
								state_q        <= S_SETTLE;
							end
						end
					endcase
				end
				S_WA: begin
					if (j_q == MAX_J) begin
						kind_q  <= dcr_pkg::KIND_NONE;
						state_q <= S_FINAL;
					end else if (j_q == sts.idx) begin
						j_q <= j_q + 1'b1;
					end else begin
						cmd_q.cov_go   <= 1'b1;
						cmd_q.cov_mode <= 1'b0;
						state_q        <= S_WAW;
					end
				end
				S_WAW: begin
					if (sts.cov_done) begin
						cmd_q.adj_row  <= 1'b1;
						cmd_q.cov_go   <= 1'b1;
						cmd_q.cov_mode <= 1'b1;
						state_q        <= S_WBW;
					end
				end
				S_WBW: begin
					if (sts.cov_done) begin
						cmd_q.adj_col <= 1'b1;
						j_q           <= j_q + 1'b1;
						state_q       <= S_WA;
					end
				end
				S_RSEED: begin
					if (j_q == sts.n) begin
						state_q <= S_WALK;
					end else begin
						cmd_q.cov_go   <= 1'b1;
						cmd_q.cov_mode <= 1'b0;
						state_q        <= S_RWAIT;
					end
				end
				S_RWAIT: begin
					if (sts.cov_done) begin
						cmd_q.seed_set <= 1'b1;
						j_q            <= j_q + 1'b1;
						state_q        <= S_RSEED;
					end
				end
				S_WALK: begin
					if (sts.top_nz) begin
						if (sts.op != dcr_pkg::OP_ROCKET || sts.out_empty) begin
							cmd_q.walk_pick <= 1'b1;
							state_q         <= S_SETTLE;
						end
					end else if (sts.sp_nz) begin
						cmd_q.pop_rd <= 1'b1;
						state_q      <= S_POPW;
					end else begin
						unique case (sts.op)
							dcr_pkg::OP_ROCKET: begin
								kind_q  <= sts.pend_valid ? dcr_pkg::KIND_PEND
								                          : dcr_pkg::KIND_NONE;
								state_q <= S_FINAL;
							end
							dcr_pkg::OP_REACH: begin
								kind_q  <= dcr_pkg::KIND_REACH;
								state_q <= S_FINAL;
							end
							default: begin
								cmd_q.best_upd   <= 1'b1;
								cmd_q.best_first <= (j_q == '0);
								j_q              <= j_q + 1'b1;
								if (j_q + 1'b1 == sts.n) begin
									kind_q  <= dcr_pkg::KIND_BEST;
									state_q <= S_FINAL;
								end else begin
									state_q <= S_SEED3;
								end
							end
						endcase
					end
				end
				S_SEED3: begin
					cmd_q.seed_one <= 1'b1;
					state_q        <= S_SETTLE;
				end
				S_POPW: begin
					cmd_q.pop_load <= 1'b1;
					state_q        <= S_SETTLE;
				end
				S_SETTLE: begin
					state_q <= S_WALK;
				end
				S_FINAL: begin
					if (sts.out_empty) begin
						cmd_q.out_load <= 1'b1;
						cmd_q.kind     <= kind_q;
						ready_q        <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A command that moves the walk is issued only while an item is still taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q.walk_pick || cmd_q.pop_rd) |-> !ready_q)
		else $error("walk command while idle");
	// The final result is loaded exactly when the controller reopens for items.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q.out_load |-> ready_q && $rose(ready_q))
		else $error("result load out of step with ready");
endmodule

[sv/dcr_dp.sv]
// ----------------------------------------------------------------------------
// Disk graph chain reaction: datapath
// Mine stores, adjacency rows, disk cover unit, walk stack and result word.
// ----------------------------------------------------------------------------
module dcr_dp #(
	parameter int MAX_MINES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_acc,
	input  dcr_pkg::item_t   item_data,
	input  logic             cfg_acc,
	input  logic [6:0]       cfg_data,
	input  dcr_pkg::cmd_t    cmd,
	output dcr_pkg::sts_t    sts,
	output logic             res_valid,
	input  logic             res_ready,
	output dcr_pkg::result_t res_data
);
	localparam int IW = (MAX_MINES > 1) ? $clog2(MAX_MINES) : 1;
	localparam int CW = $clog2(MAX_MINES + 1);

	dcr_pkg::item_t     in_q;
	logic [6:0]         mc_q;
	logic [6:0]         nact;
	logic signed [15:0] x_q [MAX_MINES];
	logic signed [15:0] y_q [MAX_MINES];
	logic [14:0]        r_q [MAX_MINES];
	logic [MAX_MINES-1:0] adj_q [MAX_MINES];
	logic [MAX_MINES-1:0] act;

	logic [IW-1:0] jj;
	logic [IW-1:0] idx;
	assign jj  = cmd.j[IW-1:0];
	assign idx = in_q.mine_index[IW-1:0];
	assign nact = (mc_q > 7'(MAX_MINES)) ? 7'(MAX_MINES) : mc_q;

	always_comb begin
		for (int i = 0; i < MAX_MINES; i++) begin
			act[i] = (7'(i) < nact);
		end
	end

	// Cover unit: point (px,py) inside disk (cx,cy,r), three stages.
	logic signed [15:0] px, py, cx, cy;
	logic [14:0]        cr;
	logic signed [16:0] dx_s1, dy_s1;
	logic [14:0]        r_s1;
	logic [31:0]        dx2_s2, dy2_s2;
	logic [29:0]        r2_s2;
	logic               hit_s3;
	logic               v_s1, v_s2, v_s3;
	logic signed [33:0] dxp, dyp;

	always_comb begin
		if (cmd.cov_mode) begin
			px = in_q.pos_x;  py = in_q.pos_y;
			cx = x_q[jj];     cy = y_q[jj];     cr = r_q[jj];
		end else begin
			px = x_q[jj];     py = y_q[jj];
			cx = in_q.pos_x;  cy = in_q.pos_y;  cr = in_q.radius;
		end
	end
	assign dxp = dx_s1 * dx_s1;
	assign dyp = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.cov_go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cov_go) begin
			dx_s1 <= 17'(px) - 17'(cx);
			dy_s1 <= 17'(py) - 17'(cy);
			r_s1  <= cr;
		end
		if (v_s1) begin
			dx2_s2 <= dxp[31:0];
			dy2_s2 <= dyp[31:0];
			r2_s2  <= r_s1 * r_s1;
		end
		if (v_s2) begin
			hit_s3 <= (33'(dx2_s2) + 33'(dy2_s2)) <= 33'(r2_s2);
		end
	end

	// Walk: top frame in flops, older frames in RAM.
	logic [MAX_MINES-1:0] top_q, vis_q, top_clr, ram_rdata;
	logic [CW-1:0]        sp_q, sp_m1, cnt_q, cnt_p1, bestcnt_q, pend_cnt_q;
	logic [IW-1:0]        pick, best_q, pend_idx_q;
	logic                 pick_new, pend_valid_q;
	logic                 out_valid_q;
	dcr_pkg::result_t     out_q;

	always_comb begin
		pick = '0;
		for (int i = 0; i < MAX_MINES; i++) begin
			if (top_q[i]) begin
				pick = IW'(i);
			end
		end
	end
	assign pick_new = !vis_q[pick];
	assign sp_m1    = sp_q - 1'b1;
	assign cnt_p1   = cnt_q + 1'b1;

	always_comb begin
		top_clr       = top_q;
		top_clr[pick] = 1'b0;
	end

	dcr_ram #(.WIDTH(MAX_MINES), .DEPTH(MAX_MINES)) u_stack (
		.clk   (clk),
		.we    (cmd.walk_pick && pick_new),
		.waddr (sp_q[IW-1:0]),
		.wdata (top_clr),
		.raddr (sp_m1[IW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (item_acc) begin
			in_q <= item_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q <= '0;
			for (int i = 0; i < MAX_MINES; i++) begin
				x_q[i]   <= '0;
				y_q[i]   <= '0;
				r_q[i]   <= '0;
				adj_q[i] <= '0;
			end
		end else begin
			if (cfg_acc) begin
				mc_q <= cfg_data;
			end
			if (cmd.wr_mine) begin
				x_q[idx] <= in_q.pos_x;
				y_q[idx] <= in_q.pos_y;
				r_q[idx] <= in_q.radius;
			end
			if (cmd.adj_row) begin
				adj_q[idx][jj] <= hit_s3;
			end
			if (cmd.adj_col) begin
				adj_q[jj][idx] <= hit_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= '0;
			vis_q        <= '0;
			sp_q         <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_idx_q   <= '0;
			pend_cnt_q   <= '0;
			best_q       <= '0;
			bestcnt_q    <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.seed_clear || cmd.seed_one) begin
				top_q        <= '0;
				vis_q        <= '0;
				sp_q         <= '0;
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
				if (cmd.seed_one) begin
					top_q[jj] <= 1'b1;
				end
			end
			if (cmd.seed_set) begin
				top_q[jj] <= top_q[jj] | hit_s3;
			end
			if (cmd.walk_pick) begin
				if (pick_new) begin
					vis_q[pick] <= 1'b1;
					cnt_q       <= cnt_p1;
					sp_q        <= sp_q + 1'b1;
					top_q       <= adj_q[pick] & act;
					if (in_q.opcode == dcr_pkg::OP_ROCKET) begin
						pend_valid_q <= 1'b1;
						pend_idx_q   <= pick;
						pend_cnt_q   <= cnt_p1;
						// The previous detonation is known not to be the last one.
						if (pend_valid_q) begin
							out_valid_q <= 1'b1;
							out_q       <= '{6'(pend_idx_q), 1'b1, 7'(pend_cnt_q),
							                1'b0, 1'b0};
						end
					end
				end else begin
					top_q <= top_clr;
				end
			end
			if (cmd.pop_rd) begin
				sp_q <= sp_m1;
			end
			if (cmd.pop_load) begin
				top_q <= ram_rdata;
			end
			if (cmd.best_upd && (cmd.best_first || cnt_q > bestcnt_q)) begin
				best_q    <= jj;
				bestcnt_q <= cnt_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				unique case (cmd.kind)
					dcr_pkg::KIND_ERR:
						out_q <= '{6'd0, 1'b0, 7'd0, 1'b1, 1'b1};
					dcr_pkg::KIND_REACH:
						out_q <= '{in_q.mine_index, 1'b1, 7'(cnt_q), 1'b0, 1'b1};
					dcr_pkg::KIND_BEST:
						out_q <= '{6'(best_q), 1'b1, 7'(bestcnt_q), 1'b0, 1'b1};
					dcr_pkg::KIND_PEND:
						out_q <= '{6'(pend_idx_q), 1'b1, 7'(pend_cnt_q), 1'b0, 1'b1};
					default:
						out_q <= '{6'd0, 1'b0, 7'd0, 1'b0, 1'b1};
				endcase
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	assign sts.op         = in_q.opcode;
	assign sts.idx        = dcr_pkg::J_W'(in_q.mine_index);
	assign sts.n          = nact;
	assign sts.cov_done   = v_s3;
	assign sts.top_nz     = |top_q;
	assign sts.sp_nz      = (sp_q != '0);
	assign sts.out_empty  = !out_valid_q;
	assign sts.pend_valid = pend_valid_q;

	// Each visit pushes one frame, so the stack never exceeds the mine count.
	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(MAX_MINES))
		else $error("walk stack overflow");
	// The visit count tracks the visited map.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == 32'($countones(vis_q)))
		else $error("visit count mismatch");
	// A rocket step or a final load never writes over an undelivered result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load || (cmd.walk_pick && in_q.opcode == dcr_pkg::OP_ROCKET))
			|-> !out_valid_q)
		else $error("result register overrun");
endmodule

[sv/disk_graph_chain_reaction.sv]
// ----------------------------------------------------------------------------
// Disk graph chain reaction
// Keeps a field of mines as disks with a reachability bitmap, and answers
// rocket blasts, reach queries and best-mine searches by depth-first walks.
// ----------------------------------------------------------------------------
// Cost: a mine write makes two passes of the 3-stage cover unit for every
// other mine slot, and a rocket one pass per active mine to seed its walk.
// Throughput: one word at a time; the best-mine search repeats the walk per
// mine. Stack pops are bound by the registered read of the frame RAM.
// Reset (arst_n low) clears mine stores, the bitmap, the walk state and the
// mine count at once; no clearing pass is needed.
module disk_graph_chain_reaction #(
	parameter int MAX_MINES = 32
) (
	input logic      clk,
	input logic      arst_n,
	dcr_item_if.sink item,
	dcr_res_if.source result,
	dcr_cfg_if.sink  cfg
);
	dcr_pkg::cmd_t cmd;
	dcr_pkg::sts_t sts;
	logic          item_ready;

	// The mine count register is always writable; the user must change it only while idle (not enforced here).
	assign cfg.ready  = 1'b1;
	assign item.ready = item_ready;

	// The controller sequences every operation; it sees only status from the
	// datapath and drives it only through registered commands.
	dcr_ctrl #(.MAX_MINES(MAX_MINES)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// The datapath holds the stores, the cover unit, the walk stack and the
	// result register that decouples the result side from the item side.
	dcr_dp #(.MAX_MINES(MAX_MINES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_acc  (item.valid && item_ready),
		.item_data (item.data),
		.cfg_acc   (cfg.valid),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_data  (result.data)
	);
endmodule
